>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wau_pkg.sv
// ----------------------------------------------------------------------------
// wau_pkg
// Opcodes, flag layout and the result function of the word unary ALU.
// ----------------------------------------------------------------------------
package wau_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned FlagsW = 4;
  localparam int unsigned CmdW   = 4;
  // Packed payload widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = ((WordW + FlagsW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((WordW + FlagsW + 7) / 8) * 8;

  localparam logic [WordW-1:0] MinNeg = 16'h8000;
  localparam logic [WordW-1:0] MaxPos = 16'h7fff;

  typedef enum logic [CmdW-1:0] {
    OP_CLR  = 4'd0,
    OP_COM  = 4'd1,
    OP_DEC  = 4'd2,
    OP_INC  = 4'd3,
    OP_NEG  = 4'd4,
    OP_TST  = 4'd5,
    OP_ASR  = 4'd6,
    OP_LSL  = 4'd7,
    OP_LSR  = 4'd8,
    OP_ROL  = 4'd9,
    OP_ROR  = 4'd10,
    OP_SEXW = 4'd11
  } op_e;

  // Bit 3 N, bit 2 Z, bit 1 V, bit 0 C.
  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  typedef struct packed {
    flags_t           flags;
    logic [WordW-1:0] result;
  } alu_out_t;

  // Result and new flags for one operation; unknown codes pass through.
  function automatic alu_out_t alu_eval(logic [CmdW-1:0] cmd, logic [WordW-1:0] x,
                                        flags_t f);
    logic [WordW-1:0] r;
    flags_t           nf;
    logic             upd_nz;
    alu_out_t         res;
    r      = x;
    nf     = f;
    upd_nz = 1'b1;
    unique case (cmd)
      OP_CLR: begin
        r  = '0;
        nf = '{n: 1'b0, z: 1'b1, v: 1'b0, c: 1'b0};
        upd_nz = 1'b0;
      end
      OP_COM: begin
        r    = ~x;
        nf.v = 1'b0;
        nf.c = 1'b1;
      end
      OP_DEC: begin
        r    = x - {{(WordW-1){1'b0}}, 1'b1};
        nf.v = (x == MinNeg);
      end
      OP_INC: begin
        r    = x + {{(WordW-1){1'b0}}, 1'b1};
        nf.v = (x == MaxPos);
      end
      OP_NEG: begin
        r    = '0 - x;
        nf.v = (x == MinNeg);
        nf.c = |x;
      end
      OP_TST: begin
        nf.v = 1'b0;
      end
      OP_ASR: begin
        r    = {x[WordW-1], x[WordW-1:1]};
        nf.c = x[0];
      end
      OP_LSL: begin
        r    = {x[WordW-2:0], 1'b0};
        nf.v = x[WordW-1] ^ x[WordW-2];
        nf.c = x[WordW-1];
      end
      OP_LSR: begin
        r    = {1'b0, x[WordW-1:1]};
        nf.c = x[0];
      end
      OP_ROL: begin
        r    = {x[WordW-2:0], f.c};
        nf.v = x[WordW-1] ^ x[WordW-2];
        nf.c = x[WordW-1];
      end
      OP_ROR: begin
        r    = {f.c, x[WordW-1:1]};
        nf.c = x[0];
      end
      OP_SEXW: begin
        r      = {WordW{x[WordW-1]}};
        nf.n   = x[WordW-1];
        nf.z   = ~|x;
        upd_nz = 1'b0;
      end
      default: begin
        upd_nz = 1'b0;
      end
    endcase
    if (upd_nz) begin
      nf.n = r[WordW-1];
      nf.z = ~|r;
    end
    res.result = r;
    res.flags  = nf;
    return res;
  endfunction

endpackage

>>> sv/word_accumulator_unary_alu.sv
// ----------------------------------------------------------------------------
// word_accumulator_unary_alu
// 16-bit unary ALU with N/Z/V/C condition code update, stream in and out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one operation per transfer. tuser carries the
//   opcode, tdata the operand in bits [15:0] and the incoming flags in
//   bits [19:16] (N, Z, V, C from bit 19 down); bits [23:20] are zero.
//   Master channel m_axis_*: one result per operation, in order. tdata
//   holds the result word in [15:0] and the new flags in [19:16].
//   Order: an accepted operation passes the input register, then the
//   result register, before tvalid rises on the master side; a stall on
//   the result side can hold it in between. Throughput: one operation per
//   clock while the receiver keeps tready high; the ALU is a single shallow
//   level of 16-bit logic between the two registers, so nothing iterates.
//   Stall: when the receiver holds tready low, the result register holds
//   its transfer and the input register holds the next operation; tready
//   on the slave side drops only once both are full. Flow resumes at full
//   rate the cycle the receiver takes the result.
//   Reset: rst_ni clears both valid flags; the block is empty and ready.
//   Unassigned opcodes return the operand and the flags unchanged.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module word_accumulator_unary_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Operation channel
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wau_pkg::InDataW-1:0]       s_axis_tdata,   // [15:0] operand, [19:16] flags_in
  input  logic [wau_pkg::CmdW-1:0]          s_axis_tuser,   // [3:0] cmd
  // Result channel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wau_pkg::OutDataW-1:0]      m_axis_tdata    // [15:0] result, [19:16] flags_out
);

  localparam int unsigned PadW = wau_pkg::OutDataW - wau_pkg::WordW - wau_pkg::FlagsW;

  // Input stage
  logic                        in_valid_q, in_valid_d;
  logic [wau_pkg::CmdW-1:0]    cmd_q;
  logic [wau_pkg::WordW-1:0]   operand_q;
  wau_pkg::flags_t             flags_q;

  // Result stage
  logic                        out_valid_q, out_valid_d;
  wau_pkg::alu_out_t           out_q;

  wau_pkg::alu_out_t           alu_res;
  logic                        in_xfer;
  logic                        out_adv;

  // The result register can load when it is empty or its transfer completes.
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign alu_res = wau_pkg::alu_eval(cmd_q, operand_q, flags_q);

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = in_valid_q;
    end
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q     <= s_axis_tuser;
      operand_q <= s_axis_tdata[wau_pkg::WordW-1:0];
      flags_q   <= wau_pkg::flags_t'(
                     s_axis_tdata[wau_pkg::WordW +: wau_pkg::FlagsW]);
    end
    if (out_adv && in_valid_q) begin
      out_q <= alu_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_q.flags, out_q.result};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_in_capture, in_xfer, in_valid_q, "accepted operation not captured")
  `ASSERT_NEXT(a_out_load, in_valid_q && out_adv,
               m_axis_tvalid && (m_axis_tdata[wau_pkg::WordW-1:0] == $past(alu_res.result)),
               "result register lost a finished operation")
  `ASSERT_NOW(a_empty_ready, !in_valid_q, s_axis_tready,
              "input stage empty but not ready")
  `ASSERT_NEXT(a_no_overwrite, in_valid_q && !out_adv, in_valid_q && $stable(operand_q),
               "stalled operation overwritten")

endmodule

>>> sim/wau_alu_checker.sv
// ----------------------------------------------------------------------------
// wau_alu_checker
// Watches both stream channels of the word unary ALU, predicts each result
// from the accepted operation and compares it with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wau_alu_checker
  import wau_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InDataW-1:0]  s_data_i,   // [15:0] operand, [19:16] flags_in
  input  logic [CmdW-1:0]     s_user_i,   // [3:0] cmd
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,   // [15:0] result, [19:16] flags_out
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int MaxPrinted = 100;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [WordW-1:0] operand;
    logic [WordW-1:0] word;
    flags_t           flags;
  } alu_outcome_t;

  alu_outcome_t outstanding_q[$];

  // Word and condition codes that one operation must produce.
  function automatic alu_outcome_t predict_unary(logic [CmdW-1:0] cmd, logic [WordW-1:0] x,
                                                 flags_t fin);
    alu_outcome_t o;
    logic [WordW-1:0] w;
    flags_t           f;
    logic             nz_from_word;
    w            = x;
    f            = fin;
    nz_from_word = 1'b1;
    case (cmd)
      OP_CLR: begin
        w            = '0;
        f            = '{n: 1'b0, z: 1'b1, v: 1'b0, c: 1'b0};
        nz_from_word = 1'b0;
      end
      OP_COM: begin
        w   = x ^ 16'hffff;
        f.v = 1'b0;
        f.c = 1'b1;
      end
      OP_DEC: begin
        w   = x + 16'hffff;
        f.v = (x == 16'h8000);
      end
      OP_INC: begin
        w   = x + 16'h0001;
        f.v = (x == 16'h7fff);
      end
      OP_NEG: begin
        w   = (x ^ 16'hffff) + 16'h0001;
        f.v = (x == 16'h8000);
        f.c = (x != 16'h0000);
      end
      OP_TST: f.v = 1'b0;
      OP_ASR: begin
        w   = $signed(x) >>> 1;
        f.c = x[0];
      end
      OP_LSL: begin
        w   = x << 1;
        f.v = x[15] != x[14];
        f.c = x[15];
      end
      OP_LSR: begin
        w   = x >> 1;
        f.c = x[0];
      end
      OP_ROL: begin
        w   = (x << 1) | {15'd0, fin.c};
        f.v = x[15] != x[14];
        f.c = x[15];
      end
      OP_ROR: begin
        w   = (x >> 1) | {fin.c, 15'd0};
        f.c = x[0];
      end
      OP_SEXW: begin
        w            = x[15] ? 16'hffff : 16'h0000;
        f.n          = x[15];
        f.z          = (x == 16'h0000);
        nz_from_word = 1'b0;
      end
      default: nz_from_word = 1'b0;
    endcase
    if (nz_from_word) begin
      f.n = w[15];
      f.z = (w == 16'h0000);
    end
    o.cmd     = cmd;
    o.operand = x;
    o.word    = w;
    o.flags   = f;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors_o < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alu_outcome_t     want;
    logic [WordW-1:0] got_word;
    flags_t           got_flags;
    if (!rst_ni) begin
      outstanding_q.delete();
    end else begin
      // Compare the result transfer first; it never belongs to this edge's input.
      if (m_valid_i && m_ready_i) begin
        got_word  = m_data_i[WordW-1:0];
        got_flags = flags_t'(m_data_i[WordW+FlagsW-1:WordW]);
        if (outstanding_q.size() == 0) begin
          report_mismatch($sformatf("result %h flags %b with no operation outstanding",
                                    got_word, got_flags));
        end else begin
          want = outstanding_q.pop_front();
          checked_o++;
          if (got_word !== want.word)
            report_mismatch($sformatf("cmd %0d operand %h: result %h, want %h",
                                      want.cmd, want.operand, got_word, want.word));
          if (got_flags !== want.flags)
            report_mismatch($sformatf("cmd %0d operand %h: flags %b, want %b",
                                      want.cmd, want.operand, got_flags, want.flags));
        end
      end
      if (s_valid_i && s_ready_i)
        outstanding_q.push_back(predict_unary(s_user_i, s_data_i[WordW-1:0],
                                              flags_t'(s_data_i[WordW+FlagsW-1:WordW])));
    end
    pending_o = outstanding_q.size();
  end

endmodule

>>> sim/word_accumulator_unary_alu_test.sv
// ----------------------------------------------------------------------------
// word_accumulator_unary_alu_test
// Drives operations into the word unary ALU under shifting idle patterns and
// a long result stall; a separate checker predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module word_accumulator_unary_alu_test;
  import wau_pkg::*;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 10;
  localparam int PhaseItems   = 550;
  localparam int HoldCycles   = 40;
  localparam int DrainCycles  = 8;
  localparam int RunLimitNs   = 5_000_000;

  // Opcode values the block does not assign; they must pass the operand through.
  localparam logic [CmdW-1:0] OpSpareLo = 4'd12;
  localparam logic [CmdW-1:0] OpSpareHi = 4'd15;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [15:0] operand, [19:16] flags_in
  logic [CmdW-1:0]     s_axis_tuser  = '0;   // [3:0] cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [15:0] result, [19:16] flags_out

  int errors;
  int pending;
  int checked;

  // Idle chance per cycle, in percent, for each side; changed between phases.
  int tx_idle_pct = 12;
  int rx_idle_pct = 69;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req  = 1'b0;
  int hold_left = 0;

  int op_seen[16];

  always #(HalfPeriod) clk_i = ~clk_i;

  word_accumulator_unary_alu dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wau_alu_checker checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_i (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .m_valid_i (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_i  (m_axis_tdata),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  // Receiver: stall at random at the current rate, or hold off for a long
  // stretch when asked so the block fills and backs up its input.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one operation and hold it until the block takes it. Idle cycles in
  // front of it carry junk on tdata/tuser with tvalid low.
  task automatic send_op(input logic [CmdW-1:0] cmd, input logic [WordW-1:0] operand,
                         input logic [FlagsW-1:0] flags);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {{(InDataW-WordW-FlagsW){1'b0}}, FlagsW'($urandom), WordW'($urandom)};
      s_axis_tuser  <= CmdW'($urandom);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-WordW-FlagsW){1'b0}}, flags, operand};
    s_axis_tuser  <= cmd;
    // Sample the handshake at the rising edge, before the block updates.
    do @(posedge clk_i); while (!s_axis_tready);
    op_seen[cmd]++;
  endtask

  // Mostly assigned opcodes; operands lean toward the words where flags turn.
  task automatic send_random_op();
    logic [CmdW-1:0]  cmd;
    logic [WordW-1:0] operand;
    if ($urandom_range(99) < 90) cmd = CmdW'($urandom_range(OP_SEXW));
    else                         cmd = CmdW'($urandom_range(OpSpareHi, OpSpareLo));
    case ($urandom_range(9))
      0:       operand = 16'h0000;
      1:       operand = 16'hffff;
      2:       operand = MinNeg;
      3:       operand = MaxPos;
      4:       operand = WordW'($urandom_range(3)) << 14 | WordW'($urandom_range(1));
      default: operand = WordW'($urandom);
    endcase
    send_op(cmd, operand, FlagsW'($urandom));
  endtask

  task automatic run_phase(input int n);
    repeat (n) send_random_op();
  endtask

  initial begin
    int kinds;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Edge cases: each opcode, wraps, overflow words, carry in/out, spares.
    send_op(OP_CLR,  16'hffff, 4'hf);
    send_op(OP_COM,  16'h0000, 4'h0);
    send_op(OP_COM,  16'hffff, 4'hf);
    send_op(OP_DEC,  MinNeg,   4'h0);
    send_op(OP_DEC,  16'h0000, 4'hf);
    send_op(OP_DEC,  16'h0001, 4'h0);
    send_op(OP_INC,  MaxPos,   4'h0);
    send_op(OP_INC,  16'hffff, 4'he);
    send_op(OP_NEG,  16'h0000, 4'hf);
    send_op(OP_NEG,  MinNeg,   4'h0);
    send_op(OP_NEG,  16'h0001, 4'h0);
    send_op(OP_TST,  16'h0000, 4'h3);
    send_op(OP_TST,  MinNeg,   4'h0);
    send_op(OP_ASR,  16'h8001, 4'h2);
    send_op(OP_LSL,  16'h4000, 4'h0);
    send_op(OP_LSL,  16'hc000, 4'h0);
    send_op(OP_LSR,  16'h0001, 4'h8);
    send_op(OP_ROL,  MinNeg,   4'h1);
    send_op(OP_ROR,  16'h0001, 4'h1);
    send_op(OP_ROR,  16'h0000, 4'h0);
    send_op(OP_SEXW, MinNeg,   4'h3);
    send_op(OP_SEXW, 16'h0000, 4'h0);
    send_op(OP_SEXW, 16'h0001, 4'hf);
    send_op(OpSpareLo, 16'ha5a5, 4'h9);
    send_op(OpSpareHi, 16'h5a5a, 4'h6);

    // Sender mostly busy, receiver mostly stalled.
    run_phase(PhaseItems);

    // Swap: sender mostly idle, receiver mostly ready.
    tx_idle_pct = 69;
    rx_idle_pct = 12;
    run_phase(PhaseItems);

    // Full rate both ways, opening with a long receiver hold-off so the
    // result and input registers fill and tready drops on the input side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_phase(PhaseItems);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain what is still in flight, then give stray results time to show.
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);

    kinds = 0;
    foreach (op_seen[i]) if (op_seen[i] > 0) kinds++;
    $display("summary: %0d results checked, %0d of 16 opcode values driven, %0d mismatches",
             checked, kinds, errors);
    $display("summary: sender-heavy, receiver-heavy and no-idle traffic, one %0d-cycle stall",
             HoldCycles);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #(RunLimitNs);
    $display("timeout: %0d results still outstanding", pending);
    $display("status: fail");
    $finish;
  end

endmodule
